// ----- sv/bgc_pkg.sv -----
`timescale 1ns / 1ps

package bgc_pkg;

  localparam int TIME_BITS  = 32;
  localparam int COUNT_BITS = 16;
  localparam int LIMIT_BITS = 16;
  localparam int CFG_INDEX_BITS = 2;

  // gesture machine states
  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_PRESSED  = 3'd1,
    ST_RELEASED = 3'd2,
    ST_SECOND   = 3'd3,
    ST_LONG     = 3'd4
  } gesture_state_t;

  // event counted at a poll
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_CLICK  = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_kind_t;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_CLICK_PRESS_LIMIT = 2'd0,
    CFG_LONG_PRESS_LIMIT  = 2'd1,
    CFG_RELEASE_GAP_LIMIT = 2'd2
  } cfg_index_t;

  localparam logic [LIMIT_BITS-1:0] CLICK_PRESS_RESET = 16'd200;
  localparam logic [LIMIT_BITS-1:0] LONG_PRESS_RESET  = 16'd1000;
  localparam logic [LIMIT_BITS-1:0] RELEASE_GAP_RESET = 16'd200;

  typedef struct packed {
    logic                 pressed;
    logic [TIME_BITS-1:0] now_time;
  } poll_t;

  typedef struct packed {
    gesture_state_t        fsm_state;
    event_kind_t           event_kind;
    logic [COUNT_BITS-1:0] click_total;
    logic [COUNT_BITS-1:0] double_total;
    logic [COUNT_BITS-1:0] long_total;
  } result_t;

  typedef struct packed {
    logic [LIMIT_BITS-1:0] click_press_limit;
    logic [LIMIT_BITS-1:0] long_press_limit;
    logic [LIMIT_BITS-1:0] release_gap_limit;
  } limits_t;

  // everything the machine carries from one poll to the next
  typedef struct packed {
    gesture_state_t        gesture_state;
    logic [TIME_BITS-1:0]  press_stamp;
    logic [TIME_BITS-1:0]  release_stamp;
    logic [COUNT_BITS-1:0] click_count;
    logic [COUNT_BITS-1:0] double_count;
    logic [COUNT_BITS-1:0] long_count;
  } core_t;

endpackage

// ----- sv/button_gesture_classifier_unit.sv -----
`timescale 1ns / 1ps
// Button gesture classifier: turns a stream of button polls into click,
// double click and long press events.
// Poll channel: poll_valid / poll_stall carry one poll beat (button level and
// a free-running time stamp). Result channel: result_valid / result_stall
// carry one result beat per poll: state after the poll, the event counted by
// it and the three wrapping event counters.
// Latency: a result is shown in the cycle after its poll is accepted.
// Throughput: one poll per clock when not stalled; the gesture state, stamps
// and counters update in the same cycle the poll is taken, so back-to-back
// polls chain through a single subtract-and-compare stage with no bubbles.
// The result register doubles as the output stage: a new poll is taken while
// the pending result is being taken in the same cycle. When the receiver
// stalls with a result waiting, poll_stall rises and the held result beat
// stays unchanged until it is taken. The user must write the limit registers
// through cfg_en / cfg_index / cfg_data only while no poll is in flight; the
// block does not enforce it. Indexes past the last register are ignored.
// Reset (rst, synchronous) returns the machine to idle, clears the stamps and
// counters, loads the default limits and empties the result register.
module button_gesture_classifier_unit
  import bgc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      poll_valid,
  output logic                      poll_stall,
  input  poll_t                     poll,
  output logic                      result_valid,
  input  logic                      result_stall,
  output result_t                   result,
  input  logic                      cfg_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [LIMIT_BITS-1:0]     cfg_data
);

  limits_t     limits;
  core_t       core;
  core_t       core_next;
  event_kind_t event_kind;
  logic        poll_fire;

  // handshake: take a poll when the result stage is empty or draining
  assign poll_stall = result_valid && result_stall;
  assign poll_fire  = poll_valid && !poll_stall;

  // limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      limits.click_press_limit <= CLICK_PRESS_RESET;
      limits.long_press_limit  <= LONG_PRESS_RESET;
      limits.release_gap_limit <= RELEASE_GAP_RESET;
    end else if (cfg_en) begin
      case (cfg_index)
        CFG_CLICK_PRESS_LIMIT: limits.click_press_limit <= cfg_data;
        CFG_LONG_PRESS_LIMIT:  limits.long_press_limit  <= cfg_data;
        CFG_RELEASE_GAP_LIMIT: limits.release_gap_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  bgc_step u_step (
    .core       (core),
    .limits     (limits),
    .poll       (poll),
    .core_next  (core_next),
    .event_kind (event_kind)
  );

  // gesture state, stamps and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      core.gesture_state <= ST_IDLE;
      core.press_stamp   <= '0;
      core.release_stamp <= '0;
      core.click_count   <= '0;
      core.double_count  <= '0;
      core.long_count    <= '0;
    end else if (poll_fire) begin
      core <= core_next;
    end
  end

  // result stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (poll_fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // result stage payload
  always_ff @(posedge clk) begin
    if (poll_fire) begin
      result.fsm_state    <= core_next.gesture_state;
      result.event_kind   <= event_kind;
      result.click_total  <= core_next.click_count;
      result.double_total <= core_next.double_count;
      result.long_total   <= core_next.long_count;
    end
  end

  // an accepted poll always shows a result next cycle
  assert property (@(posedge clk) disable iff (rst) poll_fire |=> result_valid)
    else $error("accepted poll produced no result beat");

  // every counted gesture ends back in idle
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.event_kind != EV_NONE |-> result.fsm_state == ST_IDLE)
    else $error("event reported outside idle");

  // counters move only on an accepted poll that counts an event
  assert property (@(posedge clk) disable iff (rst)
    !(poll_fire && event_kind != EV_NONE) |=>
      $stable(core.click_count) && $stable(core.double_count) && $stable(core.long_count))
    else $error("counter changed without an event");

  // result beat mirrors the machine state it was taken from
  assert property (@(posedge clk) disable iff (rst)
    poll_fire |=> result.fsm_state == core.gesture_state
      && result.click_total == core.click_count
      && result.double_total == core.double_count
      && result.long_total == core.long_count)
    else $error("result beat out of step with machine state");

endmodule

// ----- sv/bgc_step.sv -----
`timescale 1ns / 1ps

module bgc_step
  import bgc_pkg::*;
(
  input  core_t       core,
  input  limits_t     limits,
  input  poll_t       poll,
  output core_t       core_next,
  output event_kind_t event_kind
);

  logic [TIME_BITS-1:0] since_press;
  logic [TIME_BITS-1:0] since_release;
  logic                 short_press;
  logic                 long_held;
  logic                 gap_passed;

  // wrapping time differences and limit compares
  always_comb begin
    since_press   = poll.now_time - core.press_stamp;
    since_release = poll.now_time - core.release_stamp;
    short_press   = since_press < TIME_BITS'(limits.click_press_limit);
    long_held     = since_press > TIME_BITS'(limits.long_press_limit);
    gap_passed    = since_release > TIME_BITS'(limits.release_gap_limit);
  end

  // next state, stamps and counters
  always_comb begin
    core_next  = core;
    event_kind = EV_NONE;
    case (core.gesture_state)
      ST_IDLE: begin
        if (poll.pressed) begin
          core_next.gesture_state = ST_PRESSED;
          core_next.press_stamp   = poll.now_time;
        end
      end
      ST_PRESSED: begin
        if (!poll.pressed) begin
          core_next.release_stamp = poll.now_time;
          // release is judged by the click limit only
          if (short_press) begin
            core_next.gesture_state = ST_RELEASED;
          end else begin
            core_next.gesture_state = ST_IDLE;
            core_next.click_count   = core.click_count + COUNT_BITS'(1);
            event_kind              = EV_CLICK;
          end
        end else if (long_held) begin
          core_next.gesture_state = ST_LONG;
        end
      end
      ST_RELEASED: begin
        if (poll.pressed) begin
          core_next.gesture_state = ST_SECOND;
        end else if (gap_passed) begin
          core_next.gesture_state = ST_IDLE;
          core_next.click_count   = core.click_count + COUNT_BITS'(1);
          event_kind              = EV_CLICK;
        end
      end
      ST_SECOND: begin
        if (!poll.pressed) begin
          core_next.gesture_state = ST_IDLE;
          core_next.double_count  = core.double_count + COUNT_BITS'(1);
          event_kind              = EV_DOUBLE;
        end
      end
      ST_LONG: begin
        if (!poll.pressed) begin
          core_next.gesture_state = ST_IDLE;
          core_next.long_count    = core.long_count + COUNT_BITS'(1);
          event_kind              = EV_LONG;
        end
      end
      default: begin
        core_next.gesture_state = ST_IDLE;
      end
    endcase
  end

endmodule
